@@ rtl/shb_pkg.sv @@
// Shared constants, command/status codes and channel structs for the
// size bucket histogram. No dependencies; every other file uses it.

package shb_pkg;

    // table geometry
    localparam int NUM_BUCKETS  = 64;
    localparam int SIZE_BITS    = 32;
    localparam int SEG_ENTRIES  = 8;
    localparam int NUM_CELLS    = NUM_BUCKETS / SEG_ENTRIES;
    localparam int IDX_W        = $clog2(NUM_BUCKETS);
    localparam int CNT_W        = $clog2(NUM_BUCKETS + 1);
    localparam int SEG_W        = $clog2(SEG_ENTRIES);
    localparam int CELL_W       = $clog2(NUM_CELLS);
    localparam int TOTAL_W      = 64;

    // field widths
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 3;
    localparam int GROWTH_W     = 21;
    localparam int GROWTH_FRAC  = 16;
    localparam int PROD_W       = SIZE_BITS + GROWTH_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // register reset values
    localparam logic [SIZE_BITS-1:0] MIN_SIZE_RST = SIZE_BITS'(64);
    localparam logic [SIZE_BITS-1:0] MAX_SIZE_RST = SIZE_BITS'(1048576);
    localparam logic [GROWTH_W-1:0]  GROWTH_RST   = GROWTH_W'(81920);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH   = 2'd2;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BUILD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd5;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TRUNC = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_INDEX = 3'd4;

    // lookup broadcast to every cell
    typedef struct packed {
        logic                 search;   // 1: first bound >= size, 0: entry at target
        logic                 sub;
        logic [SIZE_BITS-1:0] size;
        logic [IDX_W-1:0]     target;
    } shb_op_t;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [IDX_W-1:0]     bucket;
        logic [SIZE_BITS-1:0] bound;
        logic [TOTAL_W-1:0]   total;
    } shb_token_t;

    // table write broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic                 clear;
        logic [IDX_W-1:0]     addr;
        logic [SIZE_BITS-1:0] bound;
        logic [TOTAL_W-1:0]   total;
    } shb_wr_t;

endpackage

@@ rtl/shb_ifs.sv @@
// Command and result channel interfaces of the size bucket histogram.
// Depends on shb_pkg for field widths.

interface shb_req_if;
    logic                           valid;
    logic                           ready;
    logic [shb_pkg::CMD_W-1:0]      cmd;
    logic [shb_pkg::SIZE_BITS-1:0]  size;
    logic [shb_pkg::IDX_W-1:0]      index;
    logic [shb_pkg::SIZE_BITS-1:0]  entry_bound;
    logic [shb_pkg::TOTAL_W-1:0]    entry_total;

    modport source (output valid, cmd, size, index, entry_bound, entry_total,
                    input ready);
    modport sink   (input valid, cmd, size, index, entry_bound, entry_total,
                    output ready);
endinterface

interface shb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [shb_pkg::STATUS_W-1:0]   status;
    logic [shb_pkg::IDX_W-1:0]      bucket;
    logic [shb_pkg::SIZE_BITS-1:0]  bound;
    logic [shb_pkg::TOTAL_W-1:0]    total;
    logic [shb_pkg::CNT_W-1:0]      bucket_count;

    modport source (output valid, status, bucket, bound, total, bucket_count,
                    input ready);
    modport sink   (input valid, status, bucket, bound, total, bucket_count,
                    output ready);
endinterface

@@ rtl/size_bucket_histogram.sv @@
// Top level of the size bucket histogram: sequencer plus a chain of cells.
// Depends on shb_pkg, shb_ifs, shb_cell, shb_ctrl.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        cmd, size, index, entry_bound, entry_total
//   rsp      out  valid/ready        status, bucket, bound, total, bucket_count
//   cfg      in   cfg_wr_en          cfg_index, cfg_data
//
// Add, subtract and read launch a lookup token that crosses one cell (eight
// buckets) per cycle. A size above the last bound walks the chain twice.
// Build passes through a multiply state and a truncate state for each grown
// bound. Clear, load and rejected commands go straight to the result register.
// Reset empties the table at once; req is stalled while a command runs, and a
// stalled rsp holds the finished item; the next command runs and waits for it
// before its own result is loaded.

module size_bucket_histogram (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [shb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shb_pkg::CFG_DATA_W-1:0]    cfg_data,
    shb_req_if.sink                           req,
    shb_rsp_if.source                         rsp
);

    logic [shb_pkg::CNT_W-1:0] count;
    shb_pkg::shb_op_t          op;
    shb_pkg::shb_wr_t          wr;
    shb_pkg::shb_token_t       tok [shb_pkg::NUM_CELLS + 1];

    shb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .count     (count),
        .op        (op),
        .wr        (wr),
        .launch    (tok[0]),
        .chain_out (tok[shb_pkg::NUM_CELLS])
    );

    // row of bucket cells, token passes left to right
    for (genvar c = 0; c < shb_pkg::NUM_CELLS; c++) begin : g_cell
        shb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pos     (shb_pkg::CELL_W'(c)),
            .count   (count),
            .op      (op),
            .wr      (wr),
            .tok_in  (tok[c]),
            .tok_out (tok[c+1])
        );
    end

endmodule

@@ rtl/shb_cell.sv @@
// One cell of the bucket chain: a segment of bounds and totals plus a token
// stage. Depends on shb_pkg.

module shb_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [shb_pkg::CELL_W-1:0]    pos,
    input  logic [shb_pkg::CNT_W-1:0]     count,
    input  shb_pkg::shb_op_t              op,
    input  shb_pkg::shb_wr_t              wr,
    input  shb_pkg::shb_token_t           tok_in,
    output shb_pkg::shb_token_t           tok_out
);

    logic [shb_pkg::SIZE_BITS-1:0] bound_mem [shb_pkg::SEG_ENTRIES];
    logic [shb_pkg::TOTAL_W-1:0]   total_mem [shb_pkg::SEG_ENTRIES];

    logic [shb_pkg::SEG_ENTRIES-1:0] hit;
    logic [shb_pkg::SEG_W-1:0]       sel;
    logic                            any_hit;
    logic                            take;
    logic [shb_pkg::SIZE_BITS-1:0]   sel_bound;
    logic [shb_pkg::TOTAL_W-1:0]     sel_total;
    logic [shb_pkg::TOTAL_W-1:0]     new_total;
    logic                            wr_here;
    shb_pkg::shb_token_t             tok_reg;
    shb_pkg::shb_token_t             tok_next;

    // match each entry of the segment against the lookup
    for (genvar j = 0; j < shb_pkg::SEG_ENTRIES; j++) begin : g_hit
        logic [shb_pkg::IDX_W-1:0] gidx;
        assign gidx   = {pos, shb_pkg::SEG_W'(j)};
        assign hit[j] = op.search
                      ? (({1'b0, gidx} < count) && (bound_mem[j] >= op.size))
                      : (gidx == op.target);
    end

    // pick the lowest matching entry
    always_comb
    begin
        sel     = '0;
        any_hit = 1'b0;
        for (int j = shb_pkg::SEG_ENTRIES - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                sel     = shb_pkg::SEG_W'(j);
                any_hit = 1'b1;
            end
        end
    end

    assign sel_bound = bound_mem[sel];
    assign sel_total = total_mem[sel];
    assign new_total = op.sub ? (sel_total - shb_pkg::TOTAL_W'(op.size))
                              : (sel_total + shb_pkg::TOTAL_W'(op.size));
    assign take      = tok_in.valid && !tok_in.found && any_hit;
    assign wr_here   = wr.en && (wr.addr[shb_pkg::IDX_W-1:shb_pkg::SEG_W] == pos);

    // claim the token here or pass it on
    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found  = 1'b1;
            tok_next.bucket = {pos, sel};
            tok_next.bound  = sel_bound;
            tok_next.total  = op.search ? new_total : sel_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // segment storage: direct write, clear, or add/subtract on a hit
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < shb_pkg::SEG_ENTRIES; j++)
        begin
            if (wr_here && (wr.addr[shb_pkg::SEG_W-1:0] == shb_pkg::SEG_W'(j)))
            begin
                bound_mem[j] <= wr.bound;
                total_mem[j] <= wr.total;
            end
            else if (wr.clear)
            begin
                total_mem[j] <= '0;
            end
            else if (take && op.search && (sel == shb_pkg::SEG_W'(j)))
            begin
                total_mem[j] <= new_total;
            end
        end
    end

endmodule

@@ rtl/shb_ctrl.sv @@
// Command sequencer of the size bucket histogram: handshakes, registers,
// geometric build, chain launch and result register. Depends on shb_pkg, shb_ifs.

module shb_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [shb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shb_pkg::CFG_DATA_W-1:0]    cfg_data,
    shb_req_if.sink                           req,
    shb_rsp_if.source                         rsp,
    output logic [shb_pkg::CNT_W-1:0]         count,
    output shb_pkg::shb_op_t                  op,
    output shb_pkg::shb_wr_t                  wr,
    output shb_pkg::shb_token_t               launch,
    input  shb_pkg::shb_token_t               chain_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_BUILD  = 3'd2;
    localparam logic [2:0] S_GROW   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam logic [shb_pkg::IDX_W-1:0] LAST_SLOT =
        shb_pkg::IDX_W'(shb_pkg::NUM_BUCKETS - 1);

    logic [2:0]                      state_reg, state_next;
    logic [shb_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [shb_pkg::SIZE_BITS-1:0]   min_reg, max_reg;
    logic [shb_pkg::GROWTH_W-1:0]    growth_reg;
    logic                            launch_reg, launch_next;
    logic                            search_reg, search_next;
    logic                            sub_reg, sub_next;
    logic [shb_pkg::SIZE_BITS-1:0]   size_reg, size_next;
    logic [shb_pkg::IDX_W-1:0]       target_reg, target_next;
    logic [shb_pkg::SIZE_BITS-1:0]   cur_reg, cur_next;
    logic [shb_pkg::IDX_W-1:0]       n_reg, n_next;
    logic [shb_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [shb_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [shb_pkg::IDX_W-1:0]       res_bucket_reg, res_bucket_next;
    logic [shb_pkg::SIZE_BITS-1:0]   res_bound_reg, res_bound_next;
    logic [shb_pkg::TOTAL_W-1:0]     res_total_reg, res_total_next;
    logic                            out_valid_reg, out_valid_next;
    logic [shb_pkg::STATUS_W-1:0]    out_status_reg;
    logic [shb_pkg::IDX_W-1:0]       out_bucket_reg;
    logic [shb_pkg::SIZE_BITS-1:0]   out_bound_reg;
    logic [shb_pkg::TOTAL_W-1:0]     out_total_reg;
    logic [shb_pkg::CNT_W-1:0]       out_count_reg;
    logic                            accept;
    logic                            out_free;
    logic                            out_load;
    logic                            grow_sat;
    logic [shb_pkg::SIZE_BITS-1:0]   grow_val;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == S_EMIT) && out_free;
    assign req.ready = (state_reg == S_IDLE);

    // truncate the Q37.16 product; anything past the size width saturates
    assign grow_sat = |prod_reg[shb_pkg::PROD_W-1:shb_pkg::GROWTH_FRAC+shb_pkg::SIZE_BITS];
    assign grow_val = prod_reg[shb_pkg::GROWTH_FRAC +: shb_pkg::SIZE_BITS];

    // sequence commands
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        launch_next     = 1'b0;
        search_next     = search_reg;
        sub_next        = sub_reg;
        size_next       = size_reg;
        target_next     = target_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_bucket_next = res_bucket_reg;
        res_bound_next  = res_bound_reg;
        res_total_next  = res_total_reg;
        wr              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next       = req.size;
                    sub_next        = (req.cmd == shb_pkg::CMD_SUB);
                    res_status_next = shb_pkg::STATUS_OK;
                    res_bucket_next = '0;
                    res_bound_next  = '0;
                    res_total_next  = '0;
                    state_next      = S_EMIT;
                    case (req.cmd)
                        shb_pkg::CMD_ADD, shb_pkg::CMD_SUB:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = shb_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                search_next = 1'b1;
                                launch_next = 1'b1;
                                state_next  = S_SEARCH;
                            end
                        end
                        shb_pkg::CMD_READ:
                        begin
                            if ({1'b0, req.index} >= count_reg)
                            begin
                                res_status_next = shb_pkg::STATUS_INDEX;
                                res_bucket_next = req.index;
                            end
                            else
                            begin
                                search_next = 1'b0;
                                target_next = req.index;
                                launch_next = 1'b1;
                                state_next  = S_SEARCH;
                            end
                        end
                        shb_pkg::CMD_CLEAR:
                        begin
                            wr.clear = 1'b1;
                        end
                        shb_pkg::CMD_BUILD:
                        begin
                            cur_next   = min_reg;
                            n_next     = '0;
                            state_next = S_BUILD;
                        end
                        shb_pkg::CMD_LOAD:
                        begin
                            if ({1'b0, req.index} > count_reg)
                            begin
                                res_status_next = shb_pkg::STATUS_INDEX;
                                res_bucket_next = req.index;
                            end
                            else
                            begin
                                wr.en           = 1'b1;
                                wr.addr         = req.index;
                                wr.bound        = req.entry_bound;
                                wr.total        = req.entry_total;
                                count_next      = {1'b0, req.index} + shb_pkg::CNT_W'(1);
                                res_bucket_next = req.index;
                                res_bound_next  = req.entry_bound;
                                res_total_next  = req.entry_total;
                            end
                        end
                        default:
                        begin
                            res_status_next = shb_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (chain_out.valid)
                begin
                    if (chain_out.found)
                    begin
                        res_bucket_next = chain_out.bucket;
                        res_bound_next  = chain_out.bound;
                        res_total_next  = chain_out.total;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        // size beyond the last bound: report the last bucket
                        res_status_next = shb_pkg::STATUS_ABOVE;
                        search_next     = 1'b0;
                        target_next     = shb_pkg::IDX_W'(count_reg - shb_pkg::CNT_W'(1));
                        launch_next     = 1'b1;
                    end
                end
            end
            S_BUILD:
            begin
                if ((cur_reg < max_reg) && (n_reg < LAST_SLOT))
                begin
                    wr.en      = 1'b1;
                    wr.addr    = n_reg;
                    wr.bound   = cur_reg;
                    n_next     = n_reg + shb_pkg::IDX_W'(1);
                    prod_next  = shb_pkg::PROD_W'(cur_reg) * shb_pkg::PROD_W'(growth_reg);
                    state_next = S_GROW;
                end
                else
                begin
                    wr.en           = 1'b1;
                    wr.addr         = n_reg;
                    wr.bound        = max_reg;
                    count_next      = shb_pkg::CNT_W'(n_reg) + shb_pkg::CNT_W'(1);
                    res_status_next = (cur_reg < max_reg) ? shb_pkg::STATUS_TRUNC
                                                          : shb_pkg::STATUS_OK;
                    state_next      = S_EMIT;
                end
            end
            S_GROW:
            begin
                cur_next   = grow_sat ? max_reg : grow_val;
                state_next = S_BUILD;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            min_reg       <= shb_pkg::MIN_SIZE_RST;
            max_reg       <= shb_pkg::MAX_SIZE_RST;
            growth_reg    <= shb_pkg::GROWTH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    shb_pkg::CFG_MIN_SIZE: min_reg    <= cfg_data[shb_pkg::SIZE_BITS-1:0];
                    shb_pkg::CFG_MAX_SIZE: max_reg    <= cfg_data[shb_pkg::SIZE_BITS-1:0];
                    shb_pkg::CFG_GROWTH:   growth_reg <= cfg_data[shb_pkg::GROWTH_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        search_reg     <= search_next;
        sub_reg        <= sub_next;
        size_reg       <= size_next;
        target_reg     <= target_next;
        cur_reg        <= cur_next;
        n_reg          <= n_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_bucket_reg <= res_bucket_next;
        res_bound_reg  <= res_bound_next;
        res_total_reg  <= res_total_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bucket_reg <= res_bucket_reg;
            out_bound_reg  <= res_bound_reg;
            out_total_reg  <= res_total_reg;
            out_count_reg  <= count_reg;
        end
    end

    // drive the chain head and broadcasts
    always_comb
    begin
        launch        = '0;
        launch.valid  = launch_reg;
        op.search     = search_reg;
        op.sub        = sub_reg;
        op.size       = size_reg;
        op.target     = target_reg;
    end

    assign count            = count_reg;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.bucket       = out_bucket_reg;
    assign rsp.bound        = out_bound_reg;
    assign rsp.total        = out_total_reg;
    assign rsp.bucket_count = out_count_reg;

endmodule

@@ rtl/shb_checker.sv @@
// Port-level checks for the size bucket histogram, bound to the top level.
// Depends on shb_pkg.

module shb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [shb_pkg::STATUS_W-1:0]   rsp_status,
    input logic [shb_pkg::IDX_W-1:0]      rsp_bucket,
    input logic [shb_pkg::CNT_W-1:0]      rsp_bucket_count
);

    // one command at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while a command is in flight");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_bucket))
        else $error("stalled rsp item changed");

    // empty-table status only with an empty table
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == shb_pkg::STATUS_EMPTY) |-> rsp_bucket_count == '0)
        else $error("empty status with buckets present");

    // size above last bound reports the last bucket
    a_above_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == shb_pkg::STATUS_ABOVE)
        |-> (rsp_bucket_count != '0)
            && ({1'b0, rsp_bucket} == rsp_bucket_count - shb_pkg::CNT_W'(1)))
        else $error("above-last-bound item does not name the last bucket");

    // count never exceeds the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_bucket_count <= shb_pkg::CNT_W'(shb_pkg::NUM_BUCKETS))
        else $error("bucket count beyond table size");

endmodule

bind size_bucket_histogram shb_checker u_shb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_bucket       (rsp.bucket),
    .rsp_bucket_count (rsp.bucket_count)
);
